// ----- rtl/mtdc_pkg.sv -----
// Shared constants and the divider step function of the track duplicate classifier.
package mtdc_pkg;

  // Number of input features of the hidden layer and entries per hidden row.
  localparam int NUM_FEATURES = 3;
  localparam int HIDDEN_ROW = NUM_FEATURES + 1;

  // Width of one Q8.8 feature and of the logit result.
  localparam int FEAT_BITS = 16;
  localparam int LOGIT_BITS = 24;
  localparam int LOGIT_MAX = 8388607;
  localparam int LOGIT_MIN = -8388608;

  // Divider: four quotient bits per stage over a sixteen-bit quotient.
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = FEAT_BITS / DIV_BITS_PER_STAGE;

  // Configuration register indexes.
  localparam logic [0:0] REG_DECISION_LOGIT = 1'b0;

  // Action codes of an input beat.
  localparam logic ACT_WRITE    = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  // Four restoring division steps; returns the new remainder and four quotient bits.
  function automatic logic [11:0] div_step4(logic [7:0] rem, logic [3:0] bits,
                                            logic [7:0] dof);
    logic [8:0] r;
    logic [7:0] rr;
    logic [3:0] q;
    rr = rem;
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {rr, bits[i]};
      if (r >= {1'b0, dof}) begin
        r = r - {1'b0, dof};
        q[i] = 1'b1;
      end
      rr = r[7:0];
    end
    return {rr, q};
  endfunction

endpackage

// ----- rtl/mtdc_div.sv -----
// Pipelined chi-square per degree of freedom divider with saturation to the Q8.8 maximum.
module mtdc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] chi2_sum_i,
  input  logic [7:0]  dof_count_i,
  output logic [mtdc_pkg::FEAT_BITS-1:0] quot_o
);
  import mtdc_pkg::*;

  logic [7:0]  rem_q  [DIV_STAGES];
  logic [15:0] low_q  [DIV_STAGES];
  logic [15:0] quo_q  [DIV_STAGES];
  logic [7:0]  dof_q  [DIV_STAGES];
  logic        sat_q  [DIV_STAGES];

  logic [7:0]  rem_in [DIV_STAGES];
  logic [15:0] low_in [DIV_STAGES];
  logic [15:0] quo_in [DIV_STAGES];
  logic [7:0]  dof_in [DIV_STAGES];
  logic        sat_in [DIV_STAGES];
  logic [11:0] step   [DIV_STAGES];

  // Stage inputs; the quotient overflows sixteen bits exactly when the top byte reaches dof.
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem_in[s] = chi2_sum_i[23:16];
        low_in[s] = chi2_sum_i[15:0];
        quo_in[s] = '0;
        dof_in[s] = dof_count_i;
        sat_in[s] = (chi2_sum_i[23:16] >= dof_count_i);
      end else begin
        rem_in[s] = rem_q[s-1];
        low_in[s] = low_q[s-1];
        quo_in[s] = quo_q[s-1];
        dof_in[s] = dof_q[s-1];
        sat_in[s] = sat_q[s-1];
      end
      step[s] = div_step4(rem_in[s], low_in[s][15:12], dof_in[s]);
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= step[s][11:4];
        low_q[s] <= {low_in[s][11:0], 4'b0000};
        quo_q[s] <= {quo_in[s][11:0], step[s][3:0]};
        dof_q[s] <= dof_in[s];
        sat_q[s] <= sat_in[s];
      end
    end
  end

  assign quot_o = sat_q[DIV_STAGES-1] ? '1 : quo_q[DIV_STAGES-1];

endmodule

// ----- rtl/mlp_track_duplicate_classifier_core.sv -----
// Top level of the two-layer perceptron track duplicate classifier.
// Pipeline: a classify beat passes through 4 divider stages, hidden products, hidden sums,
// output products and the output register, the first of these eight registers loaded at
// acceptance, and it moves only when the output is not stalled.
// Throughput: one beat per cycle; the whole pipeline holds while the output register is full
// and not taken. Write beats update the weight registers at acceptance and give no result.
// Reset clears the valid bits and the decision threshold; weights are undefined until written.
module mlp_track_duplicate_classifier_core #(
  parameter int HIDDEN_UNITS = 8,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [5:0]         weight_index_i,
  input  logic signed [15:0] weight_value_i,
  input  logic [7:0]         hit_count_i,
  input  logic [7:0]         outlier_count_i,
  input  logic [23:0]        chi2_sum_i,
  input  logic [7:0]         dof_count_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_duplicate_o,
  output logic signed [mtdc_pkg::LOGIT_BITS-1:0] score_logit_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mtdc_pkg::*;

  localparam int StoreDepth = HIDDEN_UNITS * HIDDEN_ROW + HIDDEN_UNITS + 1;
  localparam int OutBase    = HIDDEN_UNITS * HIDDEN_ROW;
  localparam int P1W        = WEIGHT_BITS + FEAT_BITS + 1;
  localparam int HSW        = P1W + 2;
  localparam int OSW        = P1W + $clog2(HIDDEN_UNITS + 1) + 1;

  logic advance;
  logic in_accept;

  // Configuration register.
  logic signed [15:0] decision_logit_q;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DECISION_LOGIT)
                     && (paddr[1:0] == 2'b00);
  assign prdata    = ((paddr[2] == REG_DECISION_LOGIT) && (paddr[1:0] == 2'b00))
                     ? 32'(decision_logit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decision_logit_q <= '0;
    end else if (cfg_write) begin
      decision_logit_q <= pwdata[15:0];
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign in_accept  = in_valid_i && advance;

  // Weight registers, written by write beats at acceptance.
  logic signed [WEIGHT_BITS-1:0] weight_q [StoreDepth];
  logic signed [WEIGHT_BITS-1:0] wval;

  assign wval = WEIGHT_BITS'(weight_value_i);

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < StoreDepth; e++) begin
      if (in_accept && (action_i == ACT_WRITE) && (int'(weight_index_i) == e)) begin
        weight_q[e] <= wval;
      end
    end
  end

  // Divider stages; counts and valid bits travel beside it.
  logic [FEAT_BITS-1:0] chi_feat;
  logic                 dv_vld_q [DIV_STAGES];
  logic [7:0]           hit_q    [DIV_STAGES];
  logic [7:0]           outl_q   [DIV_STAGES];

  mtdc_div u_div (
    .clk_i       (clk_i),
    .en_i        (advance),
    .chi2_sum_i  (chi2_sum_i),
    .dof_count_i (dof_count_i),
    .quot_o      (chi_feat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) dv_vld_q[s] <= 1'b0;
    end else if (advance) begin
      dv_vld_q[0] <= in_valid_i && (action_i == ACT_CLASSIFY);
      for (int s = 1; s < DIV_STAGES; s++) dv_vld_q[s] <= dv_vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q[0]  <= hit_count_i;
      outl_q[0] <= outlier_count_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        hit_q[s]  <= hit_q[s-1];
        outl_q[s] <= outl_q[s-1];
      end
    end
  end

  // Hidden layer products.
  logic signed [FEAT_BITS:0] feat [NUM_FEATURES];
  logic signed [P1W-1:0] prod1_q [HIDDEN_UNITS][NUM_FEATURES];
  logic                  p1_vld_q;

  always_comb begin
    feat[0] = {1'b0, hit_q[DIV_STAGES-1], 8'h00};
    feat[1] = {1'b0, outl_q[DIV_STAGES-1], 8'h00};
    feat[2] = {1'b0, chi_feat};
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int j = 0; j < HIDDEN_UNITS; j++) begin
        for (int i = 0; i < NUM_FEATURES; i++) begin
          prod1_q[j][i] <= P1W'(weight_q[j*HIDDEN_ROW+i]) * P1W'(feat[i]);
        end
      end
    end
  end

  // Hidden sums with bias, ReLU and saturation to unsigned Q8.8.
  logic signed [HSW-1:0]  hsum [HIDDEN_UNITS];
  logic [FEAT_BITS-1:0]   hid_d [HIDDEN_UNITS];
  logic [FEAT_BITS-1:0]   hid_q [HIDDEN_UNITS];
  logic                   p2_vld_q;

  always_comb begin
    for (int j = 0; j < HIDDEN_UNITS; j++) begin
      hsum[j] = HSW'(weight_q[j*HIDDEN_ROW+NUM_FEATURES]) <<< 8;
      for (int i = 0; i < NUM_FEATURES; i++) hsum[j] = hsum[j] + HSW'(prod1_q[j][i]);
      if (hsum[j] <= 0) begin
        hid_d[j] = '0;
      end else if (hsum[j][HSW-1:FEAT_BITS+8] != '0) begin
        hid_d[j] = '1;
      end else begin
        hid_d[j] = hsum[j][FEAT_BITS+7:8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int j = 0; j < HIDDEN_UNITS; j++) hid_q[j] <= hid_d[j];
    end
  end

  // Output layer products.
  logic signed [P1W-1:0] prod2_q [HIDDEN_UNITS];
  logic                  p3_vld_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int j = 0; j < HIDDEN_UNITS; j++) begin
        prod2_q[j] <= P1W'(weight_q[OutBase+j]) * P1W'(signed'({1'b0, hid_q[j]}));
      end
    end
  end

  // Output sum with bias, floor to Q.8, saturation and threshold compare.
  logic signed [OSW-1:0]        osum;
  logic signed [OSW-1:0]        lfull;
  logic signed [LOGIT_BITS-1:0] logit_d;
  logic                         dup_d;

  always_comb begin
    osum = OSW'(weight_q[OutBase+HIDDEN_UNITS]) <<< 8;
    for (int j = 0; j < HIDDEN_UNITS; j++) osum = osum + OSW'(prod2_q[j]);
    lfull = osum >>> 8;
    if (lfull > OSW'(LOGIT_MAX)) begin
      logit_d = LOGIT_BITS'(LOGIT_MAX);
    end else if (lfull < OSW'(LOGIT_MIN)) begin
      logit_d = LOGIT_BITS'(LOGIT_MIN);
    end else begin
      logit_d = lfull[LOGIT_BITS-1:0];
    end
    dup_d = logit_d > LOGIT_BITS'(decision_logit_q);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      score_logit_o  <= logit_d;
      is_duplicate_o <= dup_d;
    end
  end

  // Valid bits of the compute stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (advance) begin
      p1_vld_q    <= dv_vld_q[DIV_STAGES-1];
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
      out_valid_o <= p3_vld_q;
    end
  end

  // The input is held back only by a full output register that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output beat");

  // A stalled output beat keeps the pipeline frozen behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(p3_vld_q)))
    else $error("pipeline moved while the output was stalled");

endmodule
